[rtl/rtcd_pkg.sv]
// ----------------------------------------------------------------------------
// rtcd_pkg
// Shared types, constants and frame tables for the radio time code decoder.
// ----------------------------------------------------------------------------
package rtcd_pkg;

  localparam int unsigned IDX_W = 6;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned FLD_W = 8;
  localparam int unsigned WD_W  = 3;

  // request kinds
  localparam logic REQ_BIT  = 1'b0;
  localparam logic REQ_MARK = 1'b1;

  localparam logic [CNT_W-1:0] FULL_FRAME = 6'd59;
  localparam logic [FLD_W-1:0] MIN_WRAP   = 8'd60;
  localparam logic [FLD_W-1:0] HOUR_WRAP  = 8'd24;
  localparam logic [FLD_W-1:0] MONTH_WRAP = 8'd13;
  localparam logic [FLD_W-1:0] FEB        = 8'd2;

  // reset values of the running clock
  localparam logic [FLD_W-1:0] RST_DAY   = 8'd1;
  localparam logic [WD_W-1:0]  RST_WDAY  = 3'd1;
  localparam logic [FLD_W-1:0] RST_MONTH = 8'd1;
  localparam logic [FLD_W-1:0] RST_YEAR  = 8'd20;

  // field valid bit positions
  localparam int unsigned V_MIN  = 0;
  localparam int unsigned V_HOUR = 1;
  localparam int unsigned V_DAY  = 2;
  localparam int unsigned V_WDAY = 3;
  localparam int unsigned V_MON  = 4;
  localparam int unsigned V_YEAR = 5;

  // parity groups
  localparam logic [1:0] GRP_MIN  = 2'd0;
  localparam logic [1:0] GRP_HOUR = 2'd1;
  localparam logic [1:0] GRP_DATE = 2'd2;

  typedef enum logic [2:0] {
    KIND_MIN,
    KIND_HOUR,
    KIND_DAY,
    KIND_WDAY,
    KIND_MON,
    KIND_YEAR,
    KIND_PARITY,
    KIND_NONE
  } kind_t;

  // what a frame position carries
  function automatic kind_t pos_kind(input logic [IDX_W-1:0] idx);
    kind_t k;
    case (idx) inside
      [6'd21:6'd27]:        k = KIND_MIN;
      [6'd29:6'd34]:        k = KIND_HOUR;
      [6'd36:6'd41]:        k = KIND_DAY;
      [6'd42:6'd44]:        k = KIND_WDAY;
      [6'd45:6'd49]:        k = KIND_MON;
      [6'd50:6'd57]:        k = KIND_YEAR;
      6'd28, 6'd35, 6'd58:  k = KIND_PARITY;
      default:              k = KIND_NONE;
    endcase
    return k;
  endfunction

  // BCD weight of a data position
  function automatic logic [FLD_W-1:0] pos_weight(input logic [IDX_W-1:0] idx);
    logic [FLD_W-1:0] w;
    case (idx) inside
      6'd21, 6'd29, 6'd36, 6'd42, 6'd45, 6'd50: w = 8'd1;
      6'd22, 6'd30, 6'd37, 6'd43, 6'd46, 6'd51: w = 8'd2;
      6'd23, 6'd31, 6'd38, 6'd44, 6'd47, 6'd52: w = 8'd4;
      6'd24, 6'd32, 6'd39, 6'd48, 6'd53:        w = 8'd8;
      6'd25, 6'd33, 6'd40, 6'd49, 6'd54:        w = 8'd10;
      6'd26, 6'd34, 6'd41, 6'd55:               w = 8'd20;
      6'd27, 6'd56:                             w = 8'd40;
      6'd57:                                    w = 8'd80;
      default:                                  w = 8'd0;
    endcase
    return w;
  endfunction

  // parity group a position belongs to
  function automatic logic [1:0] pos_group(input logic [IDX_W-1:0] idx);
    logic [1:0] g;
    case (idx) inside
      [6'd21:6'd28]: g = GRP_MIN;
      [6'd29:6'd35]: g = GRP_HOUR;
      default:       g = GRP_DATE;
    endcase
    return g;
  endfunction

  // days in month 1..12, without the leap day
  function automatic logic [FLD_W-1:0] month_len(input logic [FLD_W-1:0] mon);
    logic [FLD_W-1:0] n;
    case (mon) inside
      8'd2:                     n = 8'd28;
      8'd4, 8'd6, 8'd9, 8'd11:  n = 8'd30;
      default:                  n = 8'd31;
    endcase
    return n;
  endfunction

endpackage

[rtl/rtcd_code_if.sv]
// ----------------------------------------------------------------------------
// rtcd_code_if
// Input channel: time code bits and minute marks.
// ----------------------------------------------------------------------------
interface rtcd_code_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [rtcd_pkg::IDX_W-1:0]    bit_index;
  logic                          bit_value;
  logic [rtcd_pkg::CNT_W-1:0]    bits_received;

  modport source (output valid, req_type, bit_index, bit_value, bits_received,
                  input ready);
  modport sink (input valid, req_type, bit_index, bit_value, bits_received,
                output ready);
endinterface

[rtl/rtcd_time_if.sv]
// ----------------------------------------------------------------------------
// rtcd_time_if
// Output channel: the running clock after each item.
// ----------------------------------------------------------------------------
interface rtcd_time_if;
  logic                         valid;
  logic                         ready;
  logic [rtcd_pkg::FLD_W-1:0]   minutes;
  logic [rtcd_pkg::FLD_W-1:0]   hours;
  logic [rtcd_pkg::FLD_W-1:0]   day;
  logic [rtcd_pkg::WD_W-1:0]    weekday;
  logic [rtcd_pkg::FLD_W-1:0]   month;
  logic [rtcd_pkg::FLD_W-1:0]   year;

  modport source (output valid, minutes, hours, day, weekday, month, year,
                  input ready);
  modport sink (input valid, minutes, hours, day, weekday, month, year,
                output ready);
endinterface

[rtl/radio_time_code_decoder.sv]
// ----------------------------------------------------------------------------
// radio_time_code_decoder
// Decodes a long-wave minute-frame time code into a running clock. Each item
// on "code" is either one received bit (index 21..58 matter, others are
// dropped) or a minute mark carrying the frame bit count. Bits build BCD
// minute, hour, day, weekday, month and year; a failed even-parity check at
// bits 28, 35 and 58 invalidates the minute, hour or date group. On a mark
// with a count of 59, every valid decoded field loads the clock; fields not
// loaded free-run (minute +1 carrying into hour, day, month and year) but
// the weekday, which holds. Every item returns one result on "now" with the
// clock after the update. One item per clock passes the input register and
// the result register around a single state-update pass, unless "now"
// stalls: the result register then holds, and the input register keeps
// taking items as long as the result is free or being taken in that cycle.
// ----------------------------------------------------------------------------
module radio_time_code_decoder (
  input  logic        clk,
  input  logic        rst,
  rtcd_code_if.sink   code,
  rtcd_time_if.source now
);
  import rtcd_pkg::*;

  // input register
  logic             in_valid;
  logic             in_type;
  logic [IDX_W-1:0] in_idx;
  logic             in_val;
  logic [CNT_W-1:0] in_cnt;

  // decoder state
  logic [FLD_W-1:0] dec_min, dec_hour, dec_day, dec_mon, dec_year;
  logic [WD_W-1:0]  dec_wday;
  logic [5:0]       field_valid;
  logic [2:0]       group_parity;

  // running clock
  logic [FLD_W-1:0] clk_min, clk_hour, clk_day, clk_mon, clk_year;
  logic [WD_W-1:0]  clk_wday;

  // next values
  logic [FLD_W-1:0] dec_min_next, dec_hour_next, dec_day_next;
  logic [FLD_W-1:0] dec_mon_next, dec_year_next;
  logic [WD_W-1:0]  dec_wday_next;
  logic [5:0]       field_valid_next;
  logic [2:0]       group_parity_next;
  logic [FLD_W-1:0] clk_min_next, clk_hour_next, clk_day_next;
  logic [FLD_W-1:0] clk_mon_next, clk_year_next;
  logic [WD_W-1:0]  clk_wday_next;

  logic advance;

  // the working stage moves on when the result slot is free or draining
  assign advance    = in_valid && (!now.valid || now.ready);
  assign code.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (code.ready) begin
      in_valid <= code.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (code.ready && code.valid) begin
      in_type <= code.req_type;
      in_idx  <= code.bit_index;
      in_val  <= code.bit_value;
      in_cnt  <= code.bits_received;
    end
  end

  // -------------------------------------------------------------------------
  // bit decoding: field accumulation and group parity
  // -------------------------------------------------------------------------
  always_comb begin
    kind_t            kind;
    logic [FLD_W-1:0] w;
    logic [FLD_W-1:0] add;
    logic [1:0]       grp;
    logic             start;
    logic             par;
    logic [5:0]       clr;

    kind  = pos_kind(in_idx);
    w     = pos_weight(in_idx);
    grp   = pos_group(in_idx);
    add   = in_val ? w : '0;
    start = (in_idx == 6'd21) || (in_idx == 6'd29) || (in_idx == 6'd36);

    dec_min_next      = dec_min;
    dec_hour_next     = dec_hour;
    dec_day_next      = dec_day;
    dec_wday_next     = dec_wday;
    dec_mon_next      = dec_mon;
    dec_year_next     = dec_year;
    field_valid_next  = field_valid;
    group_parity_next = group_parity;
    par               = 1'b0;
    clr               = '0;

    if (in_type == REQ_BIT && kind != KIND_NONE) begin
      par = start ? in_val : (group_parity[grp] ^ in_val);
      group_parity_next[grp] = par;

      if (kind == KIND_PARITY) begin
        if (par) begin
          case (grp)
            GRP_MIN:  clr = 6'b000001;
            GRP_HOUR: clr = 6'b000010;
            default:  clr = 6'b111100;
          endcase
          field_valid_next = field_valid & ~clr;
        end
      end else if (w == 8'd1) begin
        // weight-1 bit opens the field
        case (kind)
          KIND_MIN:  dec_min_next  = {7'd0, in_val};
          KIND_HOUR: dec_hour_next = {7'd0, in_val};
          KIND_DAY:  dec_day_next  = {7'd0, in_val};
          KIND_WDAY: dec_wday_next = {2'd0, in_val};
          KIND_MON:  dec_mon_next  = {7'd0, in_val};
          default:   dec_year_next = {7'd0, in_val};
        endcase
        field_valid_next[kind] = 1'b1;
      end else begin
        case (kind)
          KIND_MIN:  dec_min_next  = dec_min + add;
          KIND_HOUR: dec_hour_next = dec_hour + add;
          KIND_DAY:  dec_day_next  = dec_day + add;
          KIND_WDAY: dec_wday_next = dec_wday + add[WD_W-1:0];
          KIND_MON:  dec_mon_next  = dec_mon + add;
          default:   dec_year_next = dec_year + add;
        endcase
      end
    end
  end

  // -------------------------------------------------------------------------
  // minute mark: load or free-run with carries
  // -------------------------------------------------------------------------
  always_comb begin
    logic [5:0]       ld;
    logic [FLD_W-1:0] m, h, d, mo, y, m1, limit;

    ld = (in_cnt == FULL_FRAME) ? field_valid : 6'd0;
    m  = clk_min;
    h  = clk_hour;
    d  = clk_day;
    mo = clk_mon;
    y  = clk_year;
    m1 = clk_min + 8'd1;

    if (ld[V_MIN]) begin
      m = dec_min;
    end else begin
      m = m1;
      if (m1 == MIN_WRAP) begin
        m = '0;
        h = h + 8'd1;
      end
    end

    if (ld[V_HOUR]) begin
      h = dec_hour;
    end else if (h == HOUR_WRAP) begin
      h = '0;
      d = d + 8'd1;
    end

    // leap test uses the year before any carry
    limit = month_len(mo) + {7'd0, (mo == FEB) && (y[1:0] == 2'd0)};
    if (ld[V_DAY]) begin
      d = dec_day;
    end else if (mo >= 8'd1 && mo <= 8'd12 && d > limit) begin
      d  = 8'd1;
      mo = mo + 8'd1;
    end

    if (ld[V_MON]) begin
      mo = dec_mon;
    end else if (mo == MONTH_WRAP) begin
      mo = 8'd1;
      y  = y + 8'd1;
    end

    if (ld[V_YEAR]) begin
      y = dec_year;
    end

    if (in_type == REQ_MARK) begin
      clk_min_next  = m;
      clk_hour_next = h;
      clk_day_next  = d;
      clk_mon_next  = mo;
      clk_year_next = y;
      clk_wday_next = ld[V_WDAY] ? dec_wday : clk_wday;
    end else begin
      clk_min_next  = clk_min;
      clk_hour_next = clk_hour;
      clk_day_next  = clk_day;
      clk_mon_next  = clk_mon;
      clk_year_next = clk_year;
      clk_wday_next = clk_wday;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dec_min      <= '0;
      dec_hour     <= '0;
      dec_day      <= '0;
      dec_wday     <= '0;
      dec_mon      <= '0;
      dec_year     <= '0;
      field_valid  <= '1;
      group_parity <= '0;
      clk_min      <= '0;
      clk_hour     <= '0;
      clk_day      <= RST_DAY;
      clk_wday     <= RST_WDAY;
      clk_mon      <= RST_MONTH;
      clk_year     <= RST_YEAR;
    end else if (advance) begin
      dec_min      <= dec_min_next;
      dec_hour     <= dec_hour_next;
      dec_day      <= dec_day_next;
      dec_wday     <= dec_wday_next;
      dec_mon      <= dec_mon_next;
      dec_year     <= dec_year_next;
      field_valid  <= field_valid_next;
      group_parity <= group_parity_next;
      clk_min      <= clk_min_next;
      clk_hour     <= clk_hour_next;
      clk_day      <= clk_day_next;
      clk_wday     <= clk_wday_next;
      clk_mon      <= clk_mon_next;
      clk_year     <= clk_year_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      now.valid <= 1'b0;
    end else if (advance) begin
      now.valid <= 1'b1;
    end else if (now.ready) begin
      now.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      now.minutes <= clk_min_next;
      now.hours   <= clk_hour_next;
      now.day     <= clk_day_next;
      now.weekday <= clk_wday_next;
      now.month   <= clk_mon_next;
      now.year    <= clk_year_next;
    end
  end

endmodule
